// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ANP_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ANP_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ANP_ASSERT(label, clk, rst_n, prop, msg)
`define ANP_NEVER(label, clk, rst_n, expr, msg)
`endif

`endif

// ===== rtl/anp_pkg.sv =====
package anp_pkg;

	localparam int QueueDepth = 2;

	localparam logic [7:0] CharNul   = 8'h00;
	localparam logic [7:0] CharZero  = 8'h30;
	localparam logic [7:0] CharNine  = 8'h39;
	localparam logic [7:0] CharLowA  = 8'h61;
	localparam logic [7:0] CharLowF  = 8'h66;
	localparam logic [7:0] CharUpA   = 8'h41;
	localparam logic [7:0] CharUpF   = 8'h46;
	localparam logic [7:0] CharLowX  = 8'h78;
	localparam logic [7:0] CharUpX   = 8'h58;

	typedef enum logic [1:0] {
		KIND_DIGIT  = 2'd0,
		KIND_PREFIX = 2'd1,
		KIND_BAD    = 2'd2,
		KIND_END    = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [3:0] digit;
		logic       alpha;
		logic       empty;
	} entry_t;

endpackage

// ===== rtl/anp_char_if.sv =====
interface anp_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_byte;

	modport source (output valid, output char_byte, input ready);
	modport sink (input valid, input char_byte, output ready);
endinterface

// ===== rtl/anp_result_if.sv =====
interface anp_result_if;
	logic        valid;
	logic        ready;
	logic        status;
	logic [31:0] number;

	modport source (output valid, output status, output number, input ready);
	modport sink (input valid, input status, input number, output ready);
endinterface

// ===== rtl/anp_front.sv =====
`include "assert_macros.svh"

module anp_front (
	input  logic            clk,
	input  logic            arst_n,
	anp_char_if.sink        char_in,
	output logic            push_valid,
	input  logic            push_ready,
	output anp_pkg::entry_t push_data
);
	import anp_pkg::*;

	logic [1:0] pos_q;
	logic       first_zero_q;
	logic       accept;
	logic [7:0] c;

	assign c = char_in.char_byte;
	assign char_in.ready = push_ready;
	assign push_valid = char_in.valid;
	assign accept = char_in.valid && push_ready;

	always_comb begin
		push_data.kind  = KIND_BAD;
		push_data.digit = 4'd0;
		push_data.alpha = 1'b0;
		push_data.empty = (pos_q == 2'd0);
		if (c == CharNul) begin
			push_data.kind = KIND_END;
		end else if (pos_q == 2'd1 && first_zero_q && (c == CharLowX || c == CharUpX)) begin
			push_data.kind = KIND_PREFIX;
		end else if (c >= CharZero && c <= CharNine) begin
			push_data.kind  = KIND_DIGIT;
			push_data.digit = c[3:0];
		end else if ((c >= CharLowA && c <= CharLowF) || (c >= CharUpA && c <= CharUpF)) begin
			push_data.kind  = KIND_DIGIT;
			push_data.digit = c[3:0] + 4'd9;
			push_data.alpha = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= 2'd0;
			first_zero_q <= 1'b0;
		end else if (accept) begin
			if (c == CharNul) begin
				pos_q        <= 2'd0;
				first_zero_q <= 1'b0;
			end else begin
				if (pos_q == 2'd0) begin
					first_zero_q <= (c == CharZero);
				end
				if (pos_q != 2'd2) begin
					pos_q <= pos_q + 2'd1;
				end
			end
		end
	end

	`ANP_NEVER(a_pos_range, clk, arst_n, pos_q == 2'd3, "position counter out of range")
	`ANP_ASSERT(a_prefix_pos, clk, arst_n, (push_valid && push_data.kind == KIND_PREFIX) |-> (pos_q == 2'd1 && first_zero_q), "prefix outside second byte")

endmodule

// ===== rtl/anp_queue.sv =====
`include "assert_macros.svh"

module anp_queue #(
	parameter int DEPTH = anp_pkg::QueueDepth
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  anp_pkg::entry_t push_data,
	output logic            pop_valid,
	input  logic            pop_ready,
	output anp_pkg::entry_t pop_data
);
	import anp_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	entry_t          slots_q [DEPTH];
	logic   [PW-1:0] wr_ptr_q;
	logic   [PW-1:0] rd_ptr_q;
	logic   [CW-1:0] count_q;
	logic            push;
	logic            pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = slots_q[rd_ptr_q];
	assign push = push_valid && push_ready;
	assign pop  = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`ANP_NEVER(a_count_range, clk, arst_n, count_q > CW'(DEPTH), "queue count above depth")
	`ANP_ASSERT(a_empty_ptrs, clk, arst_n, (count_q == '0) |-> (wr_ptr_q == rd_ptr_q), "pointers differ on empty queue")

endmodule

// ===== rtl/anp_back.sv =====
`include "assert_macros.svh"

module anp_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            pop_valid,
	output logic            pop_ready,
	input  anp_pkg::entry_t pop_data,
	anp_result_if.source    result_out
);
	import anp_pkg::*;

	logic [31:0] accum_q;
	logic        hex_mode_q;
	logic        need_digit_q;
	logic        err_q;
	logic        out_valid_q;
	logic        status_q;
	logic [31:0] number_q;
	logic        pop;
	logic        bad;
	logic [35:0] scaled;
	logic [35:0] next_val;
	logic        overflow;

	assign pop_ready = (pop_data.kind != KIND_END) || !out_valid_q || result_out.ready;
	assign pop = pop_valid && pop_ready;
	assign bad = err_q || need_digit_q || pop_data.empty;

	assign scaled = hex_mode_q ? {accum_q, 4'd0} : ({1'b0, accum_q, 3'd0} + {3'd0, accum_q, 1'b0});
	assign next_val = scaled + {32'd0, pop_data.digit};
	assign overflow = (next_val[35:32] != 4'd0);

	assign result_out.valid  = out_valid_q;
	assign result_out.status = status_q;
	assign result_out.number = number_q;

	always_ff @(posedge clk) begin
		if (pop && pop_data.kind == KIND_END) begin
			status_q <= bad;
			number_q <= bad ? 32'd0 : accum_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accum_q      <= 32'd0;
			hex_mode_q   <= 1'b0;
			need_digit_q <= 1'b0;
			err_q        <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (pop && pop_data.kind == KIND_END) begin
				out_valid_q <= 1'b1;
			end else if (result_out.ready) begin
				out_valid_q <= 1'b0;
			end
			if (pop) begin
				case (pop_data.kind)
					KIND_END: begin
						accum_q      <= 32'd0;
						hex_mode_q   <= 1'b0;
						need_digit_q <= 1'b0;
						err_q        <= 1'b0;
					end
					KIND_PREFIX: begin
						if (!err_q) begin
							hex_mode_q   <= 1'b1;
							need_digit_q <= 1'b1;
							accum_q      <= 32'd0;
						end
					end
					KIND_DIGIT: begin
						if (!err_q) begin
							if ((pop_data.alpha && !hex_mode_q) || overflow) begin
								err_q <= 1'b1;
							end else begin
								accum_q      <= next_val[31:0];
								need_digit_q <= 1'b0;
							end
						end
					end
					default: begin
						err_q <= 1'b1;
					end
				endcase
			end
		end
	end

	`ANP_ASSERT(a_err_zero, clk, arst_n, (out_valid_q && status_q) |-> (number_q == 32'd0), "error result carries a value")
	`ANP_ASSERT(a_need_hex, clk, arst_n, need_digit_q |-> hex_mode_q, "digit wait without hex base")

endmodule

// ===== rtl/ascii_number_parser.sv =====
// A terminating zero byte is stored in the queue, then its result is registered at the output.
// Throughput: one byte per cycle, sustained, while the result side keeps up.
// The digit step (accumulate times base plus digit, overflow check) sets the cycle.
// Reset: arst_n clears position, base, error, queue and output valid; no result pending.
module ascii_number_parser #(
	parameter int QUEUE_DEPTH = anp_pkg::QueueDepth
) (
	input  logic         clk,
	input  logic         arst_n,
	anp_char_if.sink     char_in,
	anp_result_if.source result_out
);
	import anp_pkg::*;

	logic   push_valid;
	logic   push_ready;
	entry_t push_data;
	logic   pop_valid;
	logic   pop_ready;
	entry_t pop_data;

	anp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_in    (char_in),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	anp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	anp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data),
		.result_out (result_out)
	);

endmodule
